FILE: src/bounded_set_table_assert.svh
// assertion macros for the bounded set table
`ifndef BOUNDED_SET_TABLE_ASSERT_SVH
`define BOUNDED_SET_TABLE_ASSERT_SVH

// same-cycle implication, clocked on clock, off during reset
`define BST_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define BST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/bst_pkg.sv
// package: types and constants of the bounded set table
`timescale 1ns / 1ps

package bst_pkg;

   // most entries the set can hold
   localparam int CAPACITY = 16;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   typedef enum logic [1:0] {
      FN_APPEND     = 2'd0,
      FN_REMOVE     = 2'd1,
      FN_CONTAINS   = 2'd2,
      FN_ADD_ABSENT = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_PRESENT   = 2'd3
   } status_type;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [COUNT_W-1:0]        count_type;

endpackage

FILE: src/bst_if.sv
// interfaces: request and response channels of the bounded set table
`timescale 1ns / 1ps

interface bst_req_if;
   logic               valid;
   logic               ready;
   bst_pkg::func_type  func;
   bst_pkg::value_type item_value;

   modport source (output valid, output func, output item_value, input ready);
   modport sink   (input valid, input func, input item_value, output ready);
endinterface

interface bst_rsp_if;
   logic                 valid;
   logic                 ready;
   bst_pkg::status_type  status;
   logic                 member_found;
   bst_pkg::count_type   entry_count;

   modport source (output valid, output status, output member_found, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input member_found, input entry_count,
                   output ready);
endinterface

FILE: src/bounded_set_table.sv
// top level: bounded set table with append, remove, contains and add-if-absent
//
// usage
//   req channel: one item per handshake, an operation (func) and a signed
//   32-bit item_value. rsp channel: one item per request, with status,
//   member_found (value was stored before the operation) and entry_count
//   (entries stored after it). both channels move an item when valid and
//   ready are high at a rising clock edge.
// timing
//   a request is captured in an input register; once the output register
//   is free, all entries are compared against it in parallel, the store and
//   count are updated and the response is loaded into the output register.
//   one request is taken every cycle while the response side keeps up.
// reset
//   synchronous, active high: count goes to zero and both registers empty.
//   stored values are not cleared, only entries below count are ever used.
// stall
//   while a response waits the input register still takes one more item;
//   then req.ready drops until the response is taken.
`timescale 1ns / 1ps

module bounded_set_table (
   input  logic          clock,
   input  logic          reset,
   bst_req_if.sink       req,
   bst_rsp_if.source     rsp
);

   localparam int CAP = bst_pkg::CAPACITY;
   localparam int CW  = bst_pkg::COUNT_W;

   // input register
   logic                in_valid_ff;
   bst_pkg::func_type   in_func_ff;
   bst_pkg::value_type  in_value_ff;

   // set state
   bst_pkg::value_type  entries_ff [CAP];
   bst_pkg::value_type  entries_in [CAP];
   bst_pkg::count_type  count_ff;
   bst_pkg::count_type  count_in;

   // output register
   logic                out_valid_ff;
   bst_pkg::status_type out_status_ff;
   bst_pkg::status_type out_status_in;
   logic                out_found_ff;
   bst_pkg::count_type  out_count_ff;

   logic                out_free;
   logic                work_fire;
   logic [CAP-1:0]      match;
   logic [CAP-1:0]      shift_en;
   logic                found;
   logic                full;
   logic                do_store;
   logic                do_remove;

   // handshake: output register frees when empty or taken
   assign out_free  = !out_valid_ff || rsp.ready;
   assign work_fire = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_func_ff  <= req.func;
         in_value_ff <= req.item_value;
      end
   end

   // parallel compare, only live entries count
   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         match[i] = (entries_ff[i] == in_value_ff) && (CW'(i) < count_ff);
      end
      // entries at and above the first match move down on remove
      for (int i = 0; i < CAP; i++) begin
         shift_en[i] = |(match & ((CAP'(1) << i) | ((CAP'(1) << i) - CAP'(1))));
      end
   end

   assign found = |match;
   assign full  = (count_ff >= CW'(CAP));

   // operation decode
   always_comb begin
      do_store      = 1'b0;
      do_remove     = 1'b0;
      out_status_in = bst_pkg::ST_OK;
      unique case (in_func_ff)
         bst_pkg::FN_APPEND: begin
            if (full) begin
               out_status_in = bst_pkg::ST_FULL;
            end else begin
               do_store = 1'b1;
            end
         end
         bst_pkg::FN_REMOVE: begin
            if (found) begin
               do_remove = 1'b1;
            end else begin
               out_status_in = bst_pkg::ST_NOT_FOUND;
            end
         end
         bst_pkg::FN_CONTAINS: begin
            if (!found) begin
               out_status_in = bst_pkg::ST_NOT_FOUND;
            end
         end
         bst_pkg::FN_ADD_ABSENT: begin
            if (found) begin
               out_status_in = bst_pkg::ST_PRESENT;
            end else if (full) begin
               out_status_in = bst_pkg::ST_FULL;
            end else begin
               do_store = 1'b1;
            end
         end
         default: begin
            out_status_in = bst_pkg::ST_OK;
         end
      endcase
   end

   // next store contents and count
   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < CAP; i++) begin
         entries_in[i] = entries_ff[i];
      end
      if (work_fire && do_store) begin
         count_in = count_ff + CW'(1);
         for (int i = 0; i < CAP; i++) begin
            if (count_ff == CW'(i)) begin
               entries_in[i] = in_value_ff;
            end
         end
      end else if (work_fire && do_remove) begin
         count_in = count_ff - CW'(1);
         for (int i = 0; i < CAP - 1; i++) begin
            if (shift_en[i]) begin
               entries_in[i] = entries_ff[i+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAP; i++) begin
         entries_ff[i] <= entries_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (work_fire) begin
         out_status_ff <= out_status_in;
         out_found_ff  <= found;
         out_count_ff  <= count_in;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.status       = out_status_ff;
   assign rsp.member_found = out_found_ff;
   assign rsp.entry_count  = out_count_ff;

   // checks
   `include "bounded_set_table_assert.svh"

   `BST_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(CAP),
      "entry count above capacity")

   `BST_ASSERT_NOW(a_full_at_cap, rsp.valid && rsp.status == bst_pkg::ST_FULL,
      rsp.entry_count == CW'(CAP), "full reported below capacity")

   `BST_ASSERT_NOW(a_notfound_flag, rsp.valid && rsp.status == bst_pkg::ST_NOT_FOUND,
      !rsp.member_found, "not found reported with a match")

   `BST_ASSERT_NEXT(a_count_step, 1'b1,
      count_ff == $past(count_ff) || count_ff == $past(count_ff) + CW'(1) ||
      count_ff == $past(count_ff) - CW'(1), "count moved by more than one")

endmodule

FILE: tb/tb_top.sv
// testbench top: bounded set table against a cycle-free set predictor, with random stalls
`timescale 1ns / 1ps

module tb_top;

   // cycles without any handshake before the run is declared hung
   localparam int HANG_LIMIT = 4000;
   // settle time after the last response
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_ITEMS = 1725;
   localparam int POOL_SIZE = 8;

   // one expected response item
   typedef struct {
      bst_pkg::status_type status;
      logic                member_found;
      bst_pkg::count_type  entry_count;
   } set_result_type;

   // shadow copy of the set plus the queue of responses it predicts
   class set_shadow_type;
      bst_pkg::value_type entries[bst_pkg::CAPACITY];
      int                 count;
      set_result_type     due_results[$];
      int                 mismatches;

      function new();
         count = 0;
         mismatches = 0;
      endfunction

      function int outstanding();
         return due_results.size();
      endfunction

      // apply one accepted request and queue the response it must give
      function void take_request(bst_pkg::func_type fn, bst_pkg::value_type v);
         int i;
         int pos;
         bit hit;
         set_result_type r;
         hit = 0;
         pos = 0;
         // lowest-indexed match among the stored entries
         for (i = 0; i < count; i++) begin
            if (!hit && entries[i] == v) begin
               hit = 1;
               pos = i;
            end
         end
         r.status = bst_pkg::ST_OK;
         r.member_found = hit;
         case (fn)
            bst_pkg::FN_APPEND: begin
               if (count < bst_pkg::CAPACITY) begin
                  entries[count] = v;
                  count++;
               end else begin
                  r.status = bst_pkg::ST_FULL;
               end
            end
            bst_pkg::FN_REMOVE: begin
               if (hit) begin
                  for (i = pos; i < count - 1; i++) entries[i] = entries[i + 1];
                  count--;
               end else begin
                  r.status = bst_pkg::ST_NOT_FOUND;
               end
            end
            bst_pkg::FN_CONTAINS: begin
               if (!hit) r.status = bst_pkg::ST_NOT_FOUND;
            end
            default: begin
               // presence wins over a full set
               if (hit) begin
                  r.status = bst_pkg::ST_PRESENT;
               end else if (count < bst_pkg::CAPACITY) begin
                  entries[count] = v;
                  count++;
               end else begin
                  r.status = bst_pkg::ST_FULL;
               end
            end
         endcase
         r.entry_count = bst_pkg::count_type'(count);
         due_results.push_back(r);
      endfunction

      // compare one accepted response against the oldest prediction
      function void check_response(bst_pkg::status_type st, logic found,
                                   bst_pkg::count_type cnt);
         set_result_type r;
         if (due_results.size() == 0) begin
            $error("response with nothing outstanding: status %s count %0d", st.name(), cnt);
            mismatches++;
            return;
         end
         r = due_results.pop_front();
         if (st !== r.status) begin
            $error("status: expected %s, actual %0d", r.status.name(), st);
            mismatches++;
         end
         if (found !== r.member_found) begin
            $error("member_found: expected %0b, actual %0b", r.member_found, found);
            mismatches++;
         end
         if (cnt !== r.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", r.entry_count, cnt);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   bst_req_if req_bus ();
   bst_rsp_if rsp_bus ();

   bounded_set_table dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   set_shadow_type shadow = new();

   // idle odds in percent, and a flag that switches idling off for a while
   int  send_idle_pct;
   int  recv_idle_pct;
   bit  quiet;
   int  hang_cycles;

   // values that recur, so that matches, duplicates and a full set are common
   bst_pkg::value_type pool[POOL_SIZE];

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: random backpressure, none while quiet
   always @(posedge clock) begin
      rsp_bus.ready <= quiet || ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // monitor: both channels are sampled at the edge, before any update lands
   always @(posedge clock) begin
      if (reset) begin
         hang_cycles <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) shadow.take_request(req_bus.func, req_bus.item_value);
         if (rsp_bus.valid && rsp_bus.ready)
            shadow.check_response(rsp_bus.status, rsp_bus.member_found, rsp_bus.entry_count);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            hang_cycles <= 0;
         else
            hang_cycles <= hang_cycles + 1;
         if (hang_cycles >= HANG_LIMIT) begin
            $display("bounded_set_table: mismatch");
            $finish;
         end
      end
   end

   // offer one item, after a random number of idle cycles, and wait for the handshake
   task automatic send_item(bst_pkg::func_type fn, bst_pkg::value_type v);
      while (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.func       <= fn;
      req_bus.item_value <= v;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // hold off the sender until every predicted response has come back
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (shadow.outstanding() != 0) @(posedge clock);
   endtask

   function automatic bst_pkg::value_type any_value();
      return bst_pkg::value_type'($urandom);
   endfunction

   function automatic void refill_pool();
      int k;
      for (k = 0; k < POOL_SIZE; k++) pool[k] = any_value();
      // keep an extreme in the pool now and then
      if ($urandom_range(0, 2) == 0) pool[0] = 32'sh7FFF_FFFF;
      if ($urandom_range(0, 2) == 0) pool[1] = bst_pkg::value_type'(32'h8000_0000);
   endfunction

   // growing blocks fill the set, shrinking blocks empty it again
   function automatic bst_pkg::func_type pick_func(bit growing);
      int roll;
      roll = $urandom_range(0, 99);
      if (growing) begin
         if (roll < 35) return bst_pkg::FN_APPEND;
         if (roll < 70) return bst_pkg::FN_ADD_ABSENT;
         if (roll < 85) return bst_pkg::FN_REMOVE;
         return bst_pkg::FN_CONTAINS;
      end
      if (roll < 55) return bst_pkg::FN_REMOVE;
      if (roll < 75) return bst_pkg::FN_CONTAINS;
      if (roll < 90) return bst_pkg::FN_APPEND;
      return bst_pkg::FN_ADD_ABSENT;
   endfunction

   task automatic run_traffic(int n_items);
      int  n;
      bit  growing;
      bst_pkg::value_type v;
      growing = 1;
      for (n = 0; n < n_items; n++) begin
         if (n % 48 == 0) begin
            refill_pool();
            growing = !growing;
            // one block in four runs with no idling on either side
            quiet = ($urandom_range(0, 3) == 0);
         end
         // mostly pool values, some noise from the whole range
         if ($urandom_range(0, 99) < 85) v = pool[$urandom_range(0, POOL_SIZE - 1)];
         else v = any_value();
         send_item(pick_func(growing), v);
      end
      quiet = 0;
   endtask

   initial begin
      int k;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.func       <= bst_pkg::FN_APPEND;
      req_bus.item_value <= '0;
      quiet = 0;
      send_idle_pct = 33;
      recv_idle_pct = 84;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: lookups on the empty set
      send_item(bst_pkg::FN_CONTAINS, '0);
      send_item(bst_pkg::FN_REMOVE, 32'sd5);
      // extremes of the value range, then a duplicate append
      send_item(bst_pkg::FN_APPEND, 32'sh7FFF_FFFF);
      send_item(bst_pkg::FN_APPEND, bst_pkg::value_type'(32'h8000_0000));
      send_item(bst_pkg::FN_APPEND, '0);
      send_item(bst_pkg::FN_APPEND, -32'sd1);
      send_item(bst_pkg::FN_APPEND, -32'sd1);
      // add-if-absent of a stored value, then of a new one
      send_item(bst_pkg::FN_ADD_ABSENT, '0);
      send_item(bst_pkg::FN_ADD_ABSENT, 32'sd12345);
      // fill to capacity
      for (k = 0; k < bst_pkg::CAPACITY - 6; k++)
         send_item(bst_pkg::FN_APPEND, bst_pkg::value_type'(k + 100));
      // full set: append and add-if-absent refused, presence still wins
      send_item(bst_pkg::FN_APPEND, 32'sd1);
      send_item(bst_pkg::FN_ADD_ABSENT, 32'sd7);
      send_item(bst_pkg::FN_ADD_ABSENT, bst_pkg::value_type'(32'h8000_0000));
      send_item(bst_pkg::FN_CONTAINS, -32'sd1);
      // remove only the first of two copies, then the head and the tail
      send_item(bst_pkg::FN_REMOVE, -32'sd1);
      send_item(bst_pkg::FN_REMOVE, 32'sh7FFF_FFFF);
      send_item(bst_pkg::FN_REMOVE, bst_pkg::value_type'(bst_pkg::CAPACITY - 7 + 100));
      drain_responses();

      // random phases: sender light and receiver heavy idling, then reversed, then none
      run_traffic(RANDOM_ITEMS / 3);
      drain_responses();
      send_idle_pct = 84;
      recv_idle_pct = 33;
      run_traffic(RANDOM_ITEMS / 3);
      drain_responses();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_traffic(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
      drain_responses();

      // let any stray response show up before deciding
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
         $display("bounded_set_table: match");
      end else begin
         $display("bounded_set_table: mismatch");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/bst_pkg.sv
src/bst_if.sv
src/bounded_set_table.sv
tb/tb_top.sv
